FILE: src/assert_macros.svh
// Assertion macros shared by the frame receiver RTL.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define AST_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ffsc_pkg.sv
// Shared types and constants for the fixed frame sum-check receiver.
// Used by the front, the queue, the back and the top level; no dependencies.
`timescale 1ns / 1ps

package ffsc_pkg;

    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 6;
    localparam int FRAME_LEN_DEF = 32;
    localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hA5;

    // Completed frame handed from the front to the back.
    typedef struct packed {
        logic bank;
        logic ok;
    } desc_t;

    // Buffer bank given back by the back once its last byte is read.
    typedef struct packed {
        logic valid;
        logic bank;
    } rel_t;

endpackage

FILE: src/fixed_frame_sum_check_receiver_top.sv
// Throughput: one received byte per cycle while in_stall is low; a good frame drains
// one byte per cycle while out_stall is low, from a two-bank buffer while the next
// frame fills the other bank.
// Input stalls only while both banks are held or the frame queue is full.
// Reset (rst_n, async, active low) clears position, sum, queue and output valid;
// start byte returns to 0xA5. Buffer contents are not cleared.
`timescale 1ns / 1ps

module fixed_frame_sum_check_receiver_top
    import ffsc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BYTE_W-1:0] cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] frame_byte,
    output logic [IDX_W-1:0]  byte_index,
    output logic              frame_ok,
    output logic              last
);

    localparam int PW = $clog2(FRAME_LEN);

    logic              wr_en;
    logic [PW:0]       wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [PW:0]       rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              push;
    desc_t             push_desc;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    desc_t             head;
    rel_t              rel;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    ffsc_front #(
        .FRAME_LEN (FRAME_LEN),
        .PW        (PW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .push      (push),
        .push_desc (push_desc),
        .q_full    (q_full),
        .rel       (rel)
    );

    ffsc_buf #(
        .PW (PW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ffsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    ffsc_back #(
        .FRAME_LEN (FRAME_LEN),
        .PW        (PW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (head),
        .pop        (pop),
        .rel        (rel),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .frame_ok   (frame_ok),
        .last       (last)
    );

endmodule

FILE: src/ffsc_buf.sv
// Two-bank frame byte buffer: one write port, one read port with registered data.
// Written by the front and read by the back; no package dependency.
`timescale 1ns / 1ps

module ffsc_buf #(
    parameter int PW = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [PW:0]   wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [PW:0]   rd_addr,
    output logic [7:0]    rd_data
);

    localparam int DEPTH = 2 ** (PW + 1);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rd_data_reg;

    // Store a received byte
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read on request, hold data otherwise
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/ffsc_queue.sv
// Two-entry descriptor queue between the front and the back.
// Depends on ffsc_pkg for the descriptor type.
`timescale 1ns / 1ps

module ffsc_queue
    import ffsc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    output logic  full,
    input  logic  pop,
    output desc_t head,
    output logic  empty
);

    desc_t      ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head  = ent_reg[rd_ptr_reg];
    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);

endmodule

FILE: src/ffsc_front.sv
// Front end: checks the start byte, collects frame bytes, sums and classifies frames.
// Depends on ffsc_pkg and assert_macros.svh; writes into ffsc_buf, feeds ffsc_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffsc_front
    import ffsc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF,
    parameter int PW        = $clog2(FRAME_LEN)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              cfg_valid,
    input  logic [BYTE_W-1:0] cfg_data,
    output logic              wr_en,
    output logic [PW:0]       wr_addr,
    output logic [BYTE_W-1:0] wr_data,
    output logic              push,
    output desc_t             push_desc,
    input  logic              q_full,
    input  rel_t              rel
);

    localparam logic [PW-1:0] LAST_POS = PW'(FRAME_LEN - 1);

    logic [BYTE_W-1:0] start_reg, start_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] check_reg, check_next;
    logic              wbank_reg, wbank_next;
    logic [1:0]        busy_reg, busy_next;

    logic              accept;
    logic              take;
    logic              complete;
    logic [BYTE_W-1:0] sum_add;
    logic              sum_match;

    // Stall while the bank being filled is still read out or the queue is full
    assign in_stall = busy_reg[wbank_reg] || q_full;
    assign accept   = in_valid && !in_stall;

    // Drop a byte at position zero that is not the start byte
    assign take     = accept && !((pos_reg == '0) && (rx_byte != start_reg));
    assign complete = take && (pos_reg == LAST_POS);
    assign sum_add  = sum_reg + rx_byte;
    assign sum_match = (sum_add == check_reg);

    // Write the byte into the bank being filled
    assign wr_en   = take;
    assign wr_addr = {wbank_reg, pos_reg};
    assign wr_data = rx_byte;

    // Hand a finished frame to the back
    assign push         = complete;
    assign push_desc.bank = wbank_reg;
    assign push_desc.ok   = sum_match;

    // Update start byte, position, sum, checksum, fill bank and bank hold flags
    always_comb
    begin
        start_next = start_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        check_next = check_reg;
        wbank_next = wbank_reg;
        busy_next  = busy_reg;
        if (cfg_valid)
        begin
            start_next = cfg_data;
        end
        if (take)
        begin
            if (complete)
            begin
                pos_next   = '0;
                sum_next   = '0;
                check_next = '0;
                if (sum_match)
                begin
                    wbank_next = ~wbank_reg;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == PW'(1))
                begin
                    check_next = rx_byte;
                end
                else
                begin
                    sum_next = sum_add;
                end
            end
        end
        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end
        if (complete && sum_match)
        begin
            busy_next[wbank_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= START_BYTE_RST;
            pos_reg   <= '0;
            sum_reg   <= '0;
            check_reg <= '0;
            wbank_reg <= 1'b0;
            busy_reg  <= 2'b00;
        end
        else
        begin
            start_reg <= start_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            check_reg <= check_next;
            wbank_reg <= wbank_next;
            busy_reg  <= busy_next;
        end
    end

    `AST_IMPL(a_push_room, push, !q_full, "frame pushed into a full queue")
    `AST_NEXT(a_push_restart, push, (pos_reg == '0) && (sum_reg == '0), "no restart after frame")
    `AST_NEXT(a_bank_flip, push && push_desc.ok, busy_reg[!wbank_reg], "good frame bank not held")

endmodule

FILE: src/ffsc_back.sv
// Back end: walks queued frames, reads the buffer and drives the result register.
// Depends on ffsc_pkg and assert_macros.svh; reads ffsc_buf, pops ffsc_queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffsc_back
    import ffsc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF,
    parameter int PW        = $clog2(FRAME_LEN)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  desc_t             head,
    output logic              pop,
    output rel_t              rel,
    output logic              rd_en,
    output logic [PW:0]       rd_addr,
    input  logic [BYTE_W-1:0] rd_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] frame_byte,
    output logic [IDX_W-1:0]  byte_index,
    output logic              frame_ok,
    output logic              last
);

    localparam logic [PW-1:0] LAST_POS = PW'(FRAME_LEN - 1);

    logic [PW-1:0]     idx_reg, idx_next;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_ok_reg, s1_ok_next;
    logic              s1_last_reg, s1_last_next;
    logic [PW-1:0]     s1_idx_reg, s1_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [IDX_W-1:0]  out_idx_reg, out_idx_next;
    logic              out_ok_reg, out_ok_next;
    logic              out_last_reg, out_last_next;

    logic out_free;
    logic s1_free;
    logic issue;
    logic item_last;

    // Pipeline flow: output register frees when taken, read stage when it moves on
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_free   = !s1_valid_reg || out_free;
    assign issue     = !q_empty && s1_free;
    assign item_last = !head.ok || (idx_reg == LAST_POS);

    // Retire the descriptor on its final item and give the bank back for a good frame
    assign pop       = issue && item_last;
    assign rel.valid = pop && head.ok;
    assign rel.bank  = head.bank;

    // Read the frame byte for a good frame
    assign rd_en   = issue && head.ok;
    assign rd_addr = {head.bank, idx_reg};

    // Advance the byte counter and the two stages
    always_comb
    begin
        idx_next       = idx_reg;
        s1_valid_next  = s1_valid_reg;
        s1_ok_next     = s1_ok_reg;
        s1_last_next   = s1_last_reg;
        s1_idx_next    = s1_idx_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_idx_next   = out_idx_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        if (issue)
        begin
            idx_next      = item_last ? '0 : idx_reg + 1'b1;
            s1_valid_next = 1'b1;
            s1_ok_next    = head.ok;
            s1_last_next  = item_last;
            s1_idx_next   = idx_reg;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
            out_byte_next  = s1_ok_reg ? rd_data : '0;
            out_idx_next   = s1_ok_reg ? IDX_W'(s1_idx_reg) : '0;
            out_ok_next    = s1_ok_reg;
            out_last_next  = s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        s1_ok_reg    <= s1_ok_next;
        s1_last_reg  <= s1_last_next;
        s1_idx_reg   <= s1_idx_next;
        out_byte_reg <= out_byte_next;
        out_idx_reg  <= out_idx_next;
        out_ok_reg   <= out_ok_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign byte_index = out_idx_reg;
    assign frame_ok   = out_ok_reg;
    assign last       = out_last_reg;

    `AST_NEXT(a_pop_rewind, pop, idx_reg == '0, "byte counter not rewound after frame")
    `AST_IMPL(a_reject_form, out_valid_reg && !out_ok_reg, out_last_reg && (out_byte_reg == '0) && (out_idx_reg == '0), "malformed reject result")
    `AST_IMPL(a_last_index, out_valid_reg && out_ok_reg && out_last_reg, out_idx_reg == IDX_W'(FRAME_LEN - 1), "last mark on wrong byte")

endmodule

FILE: verif/tb.sv
// Testbench for fixed_frame_sum_check_receiver_top: checks framing, start-byte search,
// checksum accept/reject and the start-byte register against a cycle-free frame predictor.
// Depends on ffsc_pkg and the top-level RTL only.
`timescale 1ns / 1ps

module tb;
    import ffsc_pkg::*;

    localparam int FRAME_LEN   = FRAME_LEN_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 10;
    localparam int CYCLE_LIMIT = 200000;

    // One byte leaving the receiver
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic              ok;
        logic              last_flag;
    } frame_res_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] rx_byte = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [BYTE_W-1:0] cfg_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] frame_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              frame_ok;
    logic              last;

    // Frame assembly copy kept by the testbench
    logic [BYTE_W-1:0] start_sel = START_BYTE_RST;
    int                asm_pos = 0;
    logic [BYTE_W-1:0] asm_store [FRAME_LEN];
    logic [BYTE_W-1:0] asm_sum = '0;
    logic [BYTE_W-1:0] asm_check = '0;
    frame_res_t        frame_out_q [$];

    logic [BYTE_W-1:0] tx_frame [FRAME_LEN];
    int                tx_idle_pct = 0;
    int                rx_idle_pct = 0;
    logic              hold_req = 1'b0;
    logic              hold_taken = 1'b0;
    int                hold_left = 0;
    int                fail_count = 0;
    int                cycle_count = 0;

    fixed_frame_sum_check_receiver_top #(.FRAME_LEN(FRAME_LEN)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .frame_ok   (frame_ok),
        .last       (last)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Drive output stall: one long hold-off on request, otherwise random idling
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99, 0) < rx_idle_pct);
        end
    end

    // Compare each accepted output request with the oldest expected byte
    always @(posedge clk)
    begin
        frame_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_out_q.size() == 0)
            begin
                $error("unexpected result: frame_byte %0h byte_index %0d frame_ok %0b last %0b",
                       frame_byte, byte_index, frame_ok, last);
                fail_count++;
            end
            else
            begin
                want = frame_out_q.pop_front();
                if (frame_byte !== want.data)
                begin
                    $error("frame_byte: expected %0h, got %0h", want.data, frame_byte);
                    fail_count++;
                end
                if (byte_index !== want.idx)
                begin
                    $error("byte_index: expected %0d, got %0d", want.idx, byte_index);
                    fail_count++;
                end
                if (frame_ok !== want.ok)
                begin
                    $error("frame_ok: expected %0b, got %0b", want.ok, frame_ok);
                    fail_count++;
                end
                if (last !== want.last_flag)
                begin
                    $error("last: expected %0b, got %0b", want.last_flag, last);
                    fail_count++;
                end
            end
        end
    end

    // Advance the frame assembly by one received byte and queue what it releases
    function automatic void assemble_byte(input logic [BYTE_W-1:0] b);
        frame_res_t r;
        // Drop anything but the start byte while searching
        if (asm_pos == 0 && b != start_sel)
            return;
        asm_store[asm_pos] = b;
        if (asm_pos == 1)
            asm_check = b;
        else
            asm_sum = asm_sum + b;
        asm_pos++;
        if (asm_pos == FRAME_LEN)
        begin
            if (asm_sum == asm_check)
            begin
                for (int i = 0; i < FRAME_LEN; i++)
                begin
                    r.data      = asm_store[i];
                    r.idx       = IDX_W'(i);
                    r.ok        = 1'b1;
                    r.last_flag = (i == FRAME_LEN - 1);
                    frame_out_q.push_back(r);
                end
            end
            else
            begin
                r = '{data: '0, idx: '0, ok: 1'b0, last_flag: 1'b1};
                frame_out_q.push_back(r);
            end
            asm_pos   = 0;
            asm_sum   = '0;
            asm_check = '0;
        end
    endfunction

    // Fill tx_frame; the checksum is wrong on purpose when good is clear
    function automatic void build_frame(input logic [BYTE_W-1:0] lead, input bit good,
                                        input bit extremes);
        logic [BYTE_W-1:0] sum;
        sum         = lead;
        tx_frame[0] = lead;
        for (int i = 2; i < FRAME_LEN; i++)
        begin
            if (extremes)
                tx_frame[i] = (i % 2 != 0) ? 8'hFF : 8'h00;
            else
                tx_frame[i] = BYTE_W'($urandom_range(255, 0));
            sum = sum + tx_frame[i];
        end
        tx_frame[1] = good ? sum : sum + BYTE_W'($urandom_range(255, 1));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_noise();
        logic [BYTE_W-1:0] v;
        do
            v = BYTE_W'($urandom_range(255, 0));
        while (v == start_sel);
        return v;
    endfunction

    // Offer one byte, idling first at random; returns right after the accepting edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if ($urandom_range(99, 0) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < tx_idle_pct);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        assemble_byte(b);
    endtask

    task automatic send_span(input int first, input int stop);
        for (int i = first; i < stop; i++)
            send_byte(tx_frame[i]);
    endtask

    // Idle the input, wait for every expected byte, then let the pipeline settle
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (frame_out_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_start(input logic [BYTE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        start_sel = value;
    endtask

    // Reset start byte; all-zero / all-one payload bytes with wrapping sum
    task automatic test_reset_start_byte();
        tx_idle_pct = 20;
        rx_idle_pct = 86;
        build_frame(START_BYTE_RST, 1'b1, 1'b1);
        send_span(0, FRAME_LEN);
        wait_drain();
    endtask

    // Drop bytes that are not the start byte, then lock onto a frame
    task automatic test_drop_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(pick_noise());
        build_frame(start_sel, 1'b1, 1'b0);
        send_span(0, FRAME_LEN);
        wait_drain();
    endtask

    // Checksum mismatch gives a single reject
    task automatic test_bad_checksum();
        tx_idle_pct = 86;
        rx_idle_pct = 20;
        build_frame(start_sel, 1'b0, 1'b0);
        send_span(0, FRAME_LEN);
        wait_drain();
    endtask

    // Change the start byte inside a frame; the frame in flight must complete
    task automatic test_midframe_config();
        logic [BYTE_W-1:0] old_start;
        old_start = start_sel;
        build_frame(start_sel, 1'b1, 1'b0);
        send_span(0, 13);
        wait_drain();
        write_start(8'h3C);
        send_span(13, FRAME_LEN);
        send_byte(old_start);
        wait_drain();
    endtask

    // Hold the output off while good frames keep coming, so the input backs up
    task automatic test_output_hold_off();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req <= 1'b1;
        repeat (2)
        begin
            build_frame(start_sel, 1'b1, 1'b0);
            send_span(0, FRAME_LEN);
        end
        send_byte(pick_noise());
        wait_drain();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_start_byte();
        test_drop_noise();
        test_bad_checksum();
        test_midframe_config();
        test_output_hold_off();
        wait_drain();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: fixed_frame_sum_check_receiver_top.f
+incdir+src
src/ffsc_pkg.sv
src/ffsc_buf.sv
src/ffsc_queue.sv
src/ffsc_front.sv
src/ffsc_back.sv
src/fixed_frame_sum_check_receiver_top.sv
verif/tb.sv
